// ----- rtl/lflt_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the login failure lockout table.
// No dependencies; used by every other file of the block.
package lflt_pkg;

   // Default table depth
   localparam int unsigned LFLT_ENTRIES = 8;

   // Failure counter ceiling
   localparam logic [7:0] COUNT_CEILING = 8'd255;

   // Configuration register reset values
   localparam logic [7:0]  FAILURE_LIMIT_RESET    = 8'd5;
   localparam logic [31:0] LOCKOUT_DURATION_RESET = 32'd60000;

   // Operation codes
   localparam logic [1:0] FUNC_CHECK = 2'd0;
   localparam logic [1:0] FUNC_FAIL  = 2'd1;
   localparam logic [1:0] FUNC_CLEAR = 2'd2;

   // Configuration register indexes
   localparam logic CSR_FAILURE_LIMIT    = 1'b0;
   localparam logic CSR_LOCKOUT_DURATION = 1'b1;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } lflt_state_type;

   // Lookup record passed from cell to cell (slot indexes travel beside it)
   typedef struct packed {
      logic        vld;
      logic [1:0]  func;
      logic [31:0] addr;
      logic [31:0] now;
      logic        hit;
      logic [7:0]  hit_fail;
      logic [31:0] hit_lock;
      logic        free;
      logic        old_vld;
      logic [31:0] old_time;
   } lflt_probe_type;

   // Write broadcast from the controller to the cells
   typedef struct packed {
      logic        en_cnt;   // write failure count and lock end
      logic        en_all;   // also set valid, address and last failure
      logic [31:0] addr;
      logic [7:0]  fail;
      logic [31:0] lock_end;
      logic [31:0] last;
   } lflt_wr_type;

endpackage

// ----- rtl/lflt_cell.sv -----
`timescale 1ns / 1ps
// One table slot plus one stage of the lookup chain.
// Depends on lflt_pkg.
module lflt_cell #(
   parameter int unsigned IDX_W    = 3,
   parameter int unsigned CELL_IDX = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  lflt_pkg::lflt_probe_type up_probe,
   input  logic [IDX_W-1:0]        up_hit_idx,
   input  logic [IDX_W-1:0]        up_free_idx,
   input  logic [IDX_W-1:0]        up_old_idx,
   input  lflt_pkg::lflt_wr_type   wr,
   input  logic [IDX_W-1:0]        wr_idx,
   output lflt_pkg::lflt_probe_type dn_probe,
   output logic [IDX_W-1:0]        dn_hit_idx,
   output logic [IDX_W-1:0]        dn_free_idx,
   output logic [IDX_W-1:0]        dn_old_idx
);
   import lflt_pkg::*;

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

   // Slot contents
   logic        valid_ff;
   logic [31:0] addr_ff;
   logic [7:0]  fail_ff;
   logic [31:0] lock_ff;
   logic [31:0] last_ff;

   // Stage registers toward the next cell
   lflt_probe_type   probe_ff, probe_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic [IDX_W-1:0] old_idx_ff, old_idx_in;

   logic sel;

   assign sel = (wr_idx == MY_IDX);

   // Slot update from the controller
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (sel && wr.en_all) begin
         valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (sel && wr.en_all) begin
         addr_ff <= wr.addr;
         last_ff <= wr.last;
      end
      if (sel && wr.en_cnt) begin
         fail_ff <= wr.fail;
         lock_ff <= wr.lock_end;
      end
   end

   // Fold this slot into the lookup record
   always_comb begin
      probe_in    = up_probe;
      hit_idx_in  = up_hit_idx;
      free_idx_in = up_free_idx;
      old_idx_in  = up_old_idx;
      // first matching active slot
      if (!up_probe.hit && valid_ff && (addr_ff == up_probe.addr)) begin
         probe_in.hit      = 1'b1;
         probe_in.hit_fail = fail_ff;
         probe_in.hit_lock = lock_ff;
         hit_idx_in        = MY_IDX;
      end
      // first free slot
      if (!up_probe.free && !valid_ff) begin
         probe_in.free = 1'b1;
         free_idx_in   = MY_IDX;
      end
      // oldest last failure, lowest slot wins ties
      if (valid_ff && (!up_probe.old_vld || (last_ff < up_probe.old_time))) begin
         probe_in.old_vld  = 1'b1;
         probe_in.old_time = last_ff;
         old_idx_in        = MY_IDX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff.vld <= 1'b0;
      end else begin
         probe_ff <= probe_in;
      end
      hit_idx_ff  <= hit_idx_in;
      free_idx_ff <= free_idx_in;
      old_idx_ff  <= old_idx_in;
   end

   assign dn_probe    = probe_ff;
   assign dn_hit_idx  = hit_idx_ff;
   assign dn_free_idx = free_idx_ff;
   assign dn_old_idx  = old_idx_ff;

endmodule

// ----- rtl/lflt_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer: configuration registers, slot choice and update, response register.
// Depends on lflt_pkg.
module lflt_ctrl #(
   parameter int unsigned IDX_W = 3
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic                    csr_index,
   input  logic [31:0]             csr_wdata,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  lflt_pkg::lflt_probe_type tail_probe,
   input  logic [IDX_W-1:0]        tail_hit_idx,
   input  logic [IDX_W-1:0]        tail_free_idx,
   input  logic [IDX_W-1:0]        tail_old_idx,
   output lflt_pkg::lflt_wr_type   wr,
   output logic [IDX_W-1:0]        wr_idx,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_locked,
   output logic                    rsp_entry_found,
   output logic [7:0]              rsp_failure_count,
   output logic                    rsp_evicted
);
   import lflt_pkg::*;

   lflt_state_type state_ff, state_in;

   logic [7:0]  limit_ff;
   logic [31:0] duration_ff;

   // Lookup result held for the update
   lflt_probe_type   p_ff;
   logic [IDX_W-1:0] hit_idx_ff, free_idx_ff, old_idx_ff;

   // Response register
   logic       rsp_valid_ff, rsp_valid_in;
   logic       locked_ff, locked_in;
   logic       found_ff, found_in;
   logic [7:0] count_ff, count_in;
   logic       evicted_ff, evicted_in;

   logic        out_free;
   logic        lock_set;
   logic        lock_live;
   logic [7:0]  base_fail;
   logic [7:0]  new_fail;
   logic [31:0] lock_end;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff    <= FAILURE_LIMIT_RESET;
         duration_ff <= LOCKOUT_DURATION_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FAILURE_LIMIT:    limit_ff    <= csr_wdata[7:0];
            CSR_LOCKOUT_DURATION: duration_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Capture the record leaving the last cell
   always_ff @(posedge clock) begin
      if (tail_probe.vld) begin
         p_ff        <= tail_probe;
         hit_idx_ff  <= tail_hit_idx;
         free_idx_ff <= tail_free_idx;
         old_idx_ff  <= tail_old_idx;
      end
   end

   // Failure arithmetic
   assign lock_set  = (p_ff.hit_lock != 32'd0);
   assign lock_live = lock_set && (p_ff.now < p_ff.hit_lock);
   assign base_fail = p_ff.hit ? p_ff.hit_fail : 8'd0;
   assign new_fail  = (base_fail < COUNT_CEILING) ? base_fail + 8'd1 : base_fail;
   assign lock_end  = p_ff.now + duration_ff;

   // Next state, slot write and response
   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      wr           = '0;
      wr_idx       = hit_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      locked_in    = locked_ff;
      found_in     = found_ff;
      count_in     = count_ff;
      evicted_in   = evicted_ff;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (tail_probe.vld) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               locked_in    = 1'b0;
               found_in     = 1'b0;
               count_in     = 8'd0;
               evicted_in   = 1'b0;
               wr.addr      = p_ff.addr;
               wr.last      = p_ff.now;
               unique case (p_ff.func)
                  FUNC_CHECK: begin
                     if (p_ff.hit) begin
                        found_in = 1'b1;
                        if (lock_live) begin
                           locked_in = 1'b1;
                           count_in  = p_ff.hit_fail;
                        end else if (lock_set) begin
                           // expired lock: clear it
                           wr.en_cnt = 1'b1;
                        end else begin
                           count_in = p_ff.hit_fail;
                        end
                     end
                  end
                  FUNC_FAIL: begin
                     found_in  = p_ff.hit;
                     wr.en_cnt = 1'b1;
                     wr.en_all = 1'b1;
                     wr.fail   = new_fail;
                     count_in  = new_fail;
                     if (new_fail >= limit_ff) begin
                        wr.lock_end = lock_end;
                     end else if (p_ff.hit) begin
                        wr.lock_end = p_ff.hit_lock;
                     end
                     if (!p_ff.hit) begin
                        if (p_ff.free) begin
                           wr_idx = free_idx_ff;
                        end else begin
                           wr_idx     = old_idx_ff;
                           evicted_in = 1'b1;
                        end
                     end
                  end
                  FUNC_CLEAR: begin
                     if (p_ff.hit) begin
                        found_in  = 1'b1;
                        wr.en_cnt = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      locked_ff  <= locked_in;
      found_ff   <= found_in;
      count_ff   <= count_in;
      evicted_ff <= evicted_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_locked        = locked_ff;
   assign rsp_entry_found   = found_ff;
   assign rsp_failure_count = count_ff;
   assign rsp_evicted       = evicted_ff;

endmodule

// ----- rtl/login_failure_lockout_table_top.sv -----
`timescale 1ns / 1ps
// Login failure lockout table: per-client failed login tracking with lockout.
// Channels: req_ (func, client_addr, now_ms) in, rsp_ (locked, entry_found,
// failure_count, evicted) out, both valid/ready; one response per transaction.
// csr_ write port: index 0 failure limit (8 bits), index 1 lockout duration
// in ms (32 bits); write only while no transaction is in flight.
// Operation: an accepted request enters a chain of ENTRIES slot cells and
// walks one cell per cycle, collecting the matching slot, the first free slot
// and the oldest slot. The controller then writes the chosen slot where the
// operation calls for it, and loads the response register.
// The record passes the cell registers, the controller's capture register and
// the response register before rsp_valid rises. One transaction is in flight
// at a time; a new request is taken only once the update has been made, so the
// block cannot take a new request before it is through with the last one.
// A waiting response does not block the next request; the update of that
// next request holds until the response register is free.
// Reset (synchronous) marks all slots empty, restores limit 5 and duration
// 60000 ms, and drops rsp_valid. Depends on lflt_pkg, lflt_cell, lflt_ctrl.
module login_failure_lockout_table_top #(
   parameter int unsigned ENTRIES = lflt_pkg::LFLT_ENTRIES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [31:0] req_client_addr,
   input  logic [31:0] req_now_ms,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_locked,
   output logic        rsp_entry_found,
   output logic [7:0]  rsp_failure_count,
   output logic        rsp_evicted
);
   import lflt_pkg::*;

   localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   lflt_probe_type   head_probe;
   lflt_probe_type   probe_chain    [ENTRIES+1];
   logic [IDX_W-1:0] hit_idx_chain  [ENTRIES+1];
   logic [IDX_W-1:0] free_idx_chain [ENTRIES+1];
   logic [IDX_W-1:0] old_idx_chain  [ENTRIES+1];

   lflt_wr_type      wr;
   logic [IDX_W-1:0] wr_idx;

   // Head of the chain: a fresh lookup record for the accepted request
   always_comb begin
      head_probe      = '0;
      head_probe.vld  = req_valid && req_ready;
      head_probe.func = req_func;
      head_probe.addr = req_client_addr;
      head_probe.now  = req_now_ms;
   end

   assign probe_chain[0]    = head_probe;
   assign hit_idx_chain[0]  = '0;
   assign free_idx_chain[0] = '0;
   assign old_idx_chain[0]  = '0;

   // Row of slot cells
   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      lflt_cell #(
         .IDX_W    (IDX_W),
         .CELL_IDX (g)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .up_probe    (probe_chain[g]),
         .up_hit_idx  (hit_idx_chain[g]),
         .up_free_idx (free_idx_chain[g]),
         .up_old_idx  (old_idx_chain[g]),
         .wr          (wr),
         .wr_idx      (wr_idx),
         .dn_probe    (probe_chain[g+1]),
         .dn_hit_idx  (hit_idx_chain[g+1]),
         .dn_free_idx (free_idx_chain[g+1]),
         .dn_old_idx  (old_idx_chain[g+1])
      );
   end

   // Sequencer and response register
   lflt_ctrl #(
      .IDX_W (IDX_W)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .tail_probe        (probe_chain[ENTRIES]),
      .tail_hit_idx      (hit_idx_chain[ENTRIES]),
      .tail_free_idx     (free_idx_chain[ENTRIES]),
      .tail_old_idx      (old_idx_chain[ENTRIES]),
      .wr                (wr),
      .wr_idx            (wr_idx),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_locked        (rsp_locked),
      .rsp_entry_found   (rsp_entry_found),
      .rsp_failure_count (rsp_failure_count),
      .rsp_evicted       (rsp_evicted)
   );

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for login_failure_lockout_table_top: random and directed
// lockout-table transactions, with a transaction-level table predictor and in-order checker.
// Depends on rtl/lflt_pkg.sv and the RTL of the block.
module testbench;
   import lflt_pkg::*;

   // Opcode that the block must ignore (reads back all zeros)
   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 600000;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] addr;
      logic [31:0] now;
   } login_attempt_type;

   typedef struct packed {
      logic       locked;
      logic       found;
      logic [7:0] count;
      logic       evicted;
   } lockout_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic        csr_index = 1'b0;
   logic [31:0] csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_func = '0;
   logic [31:0] req_client_addr = '0;
   logic [31:0] req_now_ms = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_locked;
   logic        rsp_entry_found;
   logic [7:0]  rsp_failure_count;
   logic        rsp_evicted;

   // Predicted table contents and register copies
   logic        tbl_valid    [LFLT_ENTRIES];
   logic [31:0] tbl_addr     [LFLT_ENTRIES];
   logic [7:0]  tbl_fails    [LFLT_ENTRIES];
   logic [31:0] tbl_lock_end [LFLT_ENTRIES];
   logic [31:0] tbl_last     [LFLT_ENTRIES];
   logic [7:0]  limit_setting = FAILURE_LIMIT_RESET;
   logic [31:0] duration_setting = LOCKOUT_DURATION_RESET;

   login_attempt_type  attempt_queue[$];
   lockout_result_type predicted_results[$];

   int attempts_queued = 0;
   int attempts_taken = 0;
   int results_seen = 0;
   int mismatch_count = 0;
   int locked_seen = 0;
   int evicted_seen = 0;
   int saturated_seen = 0;
   int settings_used = 1;
   int cycle_count = 0;
   int send_gap = 0;
   int hold_left = 0;
   logic send_idling = 1'b1;
   logic recv_idling = 1'b1;

   login_failure_lockout_table_top dut (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_client_addr   (req_client_addr),
      .req_now_ms        (req_now_ms),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_locked        (rsp_locked),
      .rsp_entry_found   (rsp_entry_found),
      .rsp_failure_count (rsp_failure_count),
      .rsp_evicted       (rsp_evicted)
   );

   always #10 clock = ~clock;

   // Idle length: mostly none or short, a few long
   function automatic int pick_gap(input logic enable);
      int r;
      r = $urandom_range(0, 99);
      if (!enable || r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      if (r < 98)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Table update for one accepted transaction; queues the expected response
   task automatic apply_attempt(input logic [1:0] op, input logic [31:0] addr,
                                input logic [31:0] now);
      lockout_result_type res;
      int slot;
      int oldest;
      res = '0;
      slot = -1;
      oldest = -1;
      for (int k = 0; k < LFLT_ENTRIES; k++)
         if (slot < 0 && tbl_valid[k] && tbl_addr[k] == addr)
            slot = k;
      case (op)
         FUNC_CHECK: begin
            if (slot >= 0) begin
               res.found = 1'b1;
               // expired lock drops both the lock and the count
               if (tbl_lock_end[slot] != 32'd0) begin
                  if (now < tbl_lock_end[slot]) begin
                     res.locked = 1'b1;
                  end else begin
                     tbl_fails[slot] = 8'd0;
                     tbl_lock_end[slot] = 32'd0;
                  end
               end
               res.count = tbl_fails[slot];
            end
         end
         FUNC_FAIL: begin
            if (slot >= 0) begin
               res.found = 1'b1;
            end else begin
               // first free slot, else oldest last failure (lowest index on a tie)
               for (int k = 0; k < LFLT_ENTRIES; k++)
                  if (slot < 0) begin
                     if (!tbl_valid[k])
                        slot = k;
                     else if (oldest < 0 || tbl_last[k] < tbl_last[oldest])
                        oldest = k;
                  end
               if (slot < 0) begin
                  slot = oldest;
                  res.evicted = 1'b1;
               end
               tbl_valid[slot] = 1'b1;
               tbl_addr[slot] = addr;
               tbl_fails[slot] = 8'd0;
               tbl_lock_end[slot] = 32'd0;
            end
            if (tbl_fails[slot] != COUNT_CEILING)
               tbl_fails[slot] = tbl_fails[slot] + 8'd1;
            tbl_last[slot] = now;
            if (tbl_fails[slot] >= limit_setting)
               tbl_lock_end[slot] = now + duration_setting;
            res.count = tbl_fails[slot];
         end
         FUNC_CLEAR: begin
            if (slot >= 0) begin
               res.found = 1'b1;
               tbl_fails[slot] = 8'd0;
               tbl_lock_end[slot] = 32'd0;
            end
         end
         default: ;
      endcase
      predicted_results.push_back(res);
   endtask

   // Driver: one transaction in flight on req_, random gaps between them
   always @(posedge clock) begin : req_driver
      login_attempt_type item;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            apply_attempt(req_func, req_client_addr, req_now_ms);
            attempts_taken++;
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (attempt_queue.size() > 0) begin
               item = attempt_queue.pop_front();
               req_valid <= 1'b1;
               req_func <= item.func;
               req_client_addr <= item.addr;
               req_now_ms <= item.now;
               send_gap = pick_gap(send_idling);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: random back-pressure on rsp_ and in-order response check
   always @(posedge clock) begin : rsp_monitor
      lockout_result_type want;
      lockout_result_type got;
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_locked, rsp_entry_found, rsp_failure_count, rsp_evicted};
            results_seen++;
            if (got.locked) locked_seen++;
            if (got.evicted) evicted_seen++;
            if (got.count == COUNT_CEILING) saturated_seen++;
            if (predicted_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("cycle %0d: response with no transaction pending", cycle_count);
            end else begin
               want = predicted_results.pop_front();
               if (got.locked !== want.locked || got.found !== want.found ||
                   got.count !== want.count || got.evicted !== want.evicted) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $write("cycle %0d: expected locked=%0b found=%0b count=%0d evicted=%0b",
                            cycle_count, want.locked, want.found, want.count, want.evicted);
                     $display(", got locked=%0b found=%0b count=%0d evicted=%0b",
                              got.locked, got.found, got.count, got.evicted);
                  end
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            hold_left = pick_gap(recv_idling);
            rsp_ready <= (hold_left == 0);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic queue_attempt(input logic [1:0] op, input logic [31:0] addr,
                                input logic [31:0] now);
      attempt_queue.push_back(login_attempt_type'{op, addr, now});
      attempts_queued++;
   endtask

   // Random phase: clients from a small pool, time advancing with ties and jumps
   task automatic queue_random_attempts(input int count, input int pool_size,
                                        input int fail_pct, input int clear_pct,
                                        input int tick_max, input logic [31:0] start_ms);
      logic [31:0] pool [16];
      logic [31:0] clock_ms;
      logic [31:0] addr;
      logic [1:0]  op;
      int r;
      for (int k = 0; k < 16; k++)
         pool[k] = $urandom;
      clock_ms = start_ms;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (r >= 10 && r < 98)
            clock_ms = clock_ms + $urandom_range(1, tick_max);
         else if (r >= 98)
            clock_ms = clock_ms + $urandom;
         r = $urandom_range(0, 99);
         if (r < fail_pct)
            op = FUNC_FAIL;
         else if (r < fail_pct + clear_pct)
            op = FUNC_CLEAR;
         else if (r < 98)
            op = FUNC_CHECK;
         else
            op = FUNC_UNUSED;
         addr = ($urandom_range(0, 99) < 5) ? $urandom : pool[$urandom_range(0, pool_size - 1)];
         queue_attempt(op, addr, clock_ms);
      end
   endtask

   task automatic wait_idle();
      while (attempts_taken != attempts_queued || predicted_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic csr_write(input logic index, input logic [31:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Only called with the block idle; junk in the upper limit bits must be ignored
   task automatic apply_settings(input logic [7:0] limit, input logic [31:0] duration);
      csr_write(CSR_FAILURE_LIMIT, {24'($urandom), limit});
      csr_write(CSR_LOCKOUT_DURATION, duration);
      limit_setting = limit;
      duration_setting = duration;
      settings_used++;
   endtask

   initial begin
      for (int k = 0; k < LFLT_ENTRIES; k++) begin
         tbl_valid[k] = 1'b0;
         tbl_addr[k] = '0;
         tbl_fails[k] = '0;
         tbl_lock_end[k] = '0;
         tbl_last[k] = '0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed, power-on settings: unknown client, lock, refresh, expiry, clear
      queue_attempt(FUNC_CHECK, 32'hFFFF_FFFF, 32'd0);
      queue_attempt(FUNC_CLEAR, 32'hFFFF_FFFF, 32'd0);
      queue_attempt(FUNC_UNUSED, 32'hFFFF_FFFF, 32'd0);
      for (int k = 0; k < 5; k++)
         queue_attempt(FUNC_FAIL, 32'hFFFF_FFFF, 32'd100 + k);
      queue_attempt(FUNC_CHECK, 32'hFFFF_FFFF, 32'd200);
      queue_attempt(FUNC_FAIL, 32'hFFFF_FFFF, 32'd300);
      queue_attempt(FUNC_CHECK, 32'hFFFF_FFFF, 32'd60300);
      queue_attempt(FUNC_CHECK, 32'hFFFF_FFFF, 32'd60301);
      queue_attempt(FUNC_CLEAR, 32'hFFFF_FFFF, 32'd60400);
      queue_attempt(FUNC_CHECK, 32'h0000_0000, 32'd1);
      queue_attempt(FUNC_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      wait_idle();

      // Directed, limit 1: lock end wrapping to zero and below now, full table, eviction ties
      apply_settings(8'd1, 32'h0000_1000);
      queue_attempt(FUNC_FAIL, 32'h0000_0000, 32'hFFFF_F000);
      queue_attempt(FUNC_CHECK, 32'h0000_0000, 32'hFFFF_F001);
      queue_attempt(FUNC_FAIL, 32'hA5A5_5A5A, 32'hFFFF_FF00);
      queue_attempt(FUNC_CHECK, 32'hA5A5_5A5A, 32'hFFFF_FF01);
      for (int k = 0; k < 5; k++)
         queue_attempt(FUNC_FAIL, 32'h0A00_0001 + k, 32'd7);
      queue_attempt(FUNC_FAIL, 32'h0A00_0010, 32'd8);
      queue_attempt(FUNC_FAIL, 32'h0A00_0011, 32'd8);
      queue_attempt(FUNC_CHECK, 32'h0A00_0001, 32'd9);
      wait_idle();

      // Random phases over a spread of settings
      apply_settings(8'd3, 32'd500);
      queue_random_attempts(100, 6, 50, 8, 40, $urandom);
      wait_idle();

      send_idling = 1'b0;
      recv_idling = 1'b0;
      apply_settings(8'd1, 32'd0);
      queue_random_attempts(90, 12, 60, 5, 5, 32'd0);
      wait_idle();

      // one client hammered up to the count ceiling
      send_idling = 1'b1;
      apply_settings(8'd255, 32'd60000);
      queue_random_attempts(360, 1, 90, 0, 50, $urandom);
      wait_idle();

      send_idling = 1'b0;
      recv_idling = 1'b1;
      apply_settings(8'd0, 32'hFFFF_FFFF);
      queue_random_attempts(80, 10, 55, 10, 100, $urandom);
      wait_idle();

      send_idling = 1'b1;
      apply_settings(8'd7, $urandom_range(1, 3000));
      queue_random_attempts(120, 16, 60, 5, 100, $urandom);
      wait_idle();

      apply_settings(8'd2, 32'd100);
      queue_random_attempts(80, 9, 50, 5, 60, 32'hFFFF_F800);
      wait_idle();

      apply_settings(FAILURE_LIMIT_RESET, LOCKOUT_DURATION_RESET);
      queue_random_attempts(50, 11, 60, 5, 20000, $urandom);
      wait_idle();

      repeat (LFLT_ENTRIES + 4) @(posedge clock);
      $display("run covered %0d transactions and %0d responses under %0d register settings",
               attempts_taken, results_seen, settings_used);
      $display("%0d locked checks, %0d evictions, %0d saturated counts, %0d mismatches",
               locked_seen, evicted_seen, saturated_seen, mismatch_count);
      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
